FILE: rtl/cbor_head_encoder_top_assert.svh
// assertion macros for the cbor head encoder
`ifndef CBOR_HEAD_ENCODER_TOP_ASSERT_SVH
`define CBOR_HEAD_ENCODER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CBE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbe_pkg.sv
// shared types and constants for the cbor head encoder
package cbe_pkg;

  localparam int unsigned CBE_QUEUE_DEPTH = 2;

  localparam logic [7:0] NIL_BYTE = 8'hF6;

  // additional information codes for the extended argument forms
  localparam logic [4:0] AI_ONE   = 5'h18;
  localparam logic [4:0] AI_TWO   = 5'h19;
  localparam logic [4:0] AI_FOUR  = 5'h1a;
  localparam logic [4:0] AI_EIGHT = 5'h1b;

  // major types
  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_TAG    = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  typedef enum logic [3:0] {
    REQ_UNSIGNED = 4'd0,
    REQ_SIGNED   = 4'd1,
    REQ_NEG_MAG  = 4'd2,
    REQ_BYTES    = 4'd3,
    REQ_TEXT     = 4'd4,
    REQ_ARRAY    = 4'd5,
    REQ_MAP      = 4'd6,
    REQ_TAG      = 4'd7,
    REQ_SIMPLE   = 4'd8,
    REQ_NIL      = 4'd9
  } req_kind_t;

  // one classified head waiting for serialization
  typedef struct packed {
    logic [7:0]  first;
    logic [63:0] arg;
    logic [3:0]  len;
  } head_t;

endpackage

FILE: rtl/cbor_head_encoder_top.sv
// top level of the cbor data item head encoder
// Usage:
//   A request is taken at a rising edge with start high and busy low. req_type
//   selects the kind of head (unsigned, signed, negative magnitude, byte or
//   text string, array, map, tag, simple, nil); value carries the argument.
//   Kinds 10 to 15 are taken but produce nothing.
//   Each head byte appears on out_byte for one cycle with strobe high, along
//   with head_length (1 to 9) and last on the final byte of the head.
//   When the output side is idle, the first byte of a head passes the queue, the
//   serializer's current-head register and the output registers in that order.
//   Throughput: one byte per cycle; a head has 1, 2, 3, 5 or 9 bytes depending on
//   the argument size; heads leave back to back without gaps while the next is queued.
//   A short queue between the classifier and the byte serializer lets new
//   requests enter while an earlier head is still going out; busy is high
//   while that queue is full.
//   Reset (rst, synchronous) empties the queue and drops any head in flight.
//   The receiver cannot stall: each strobe is one accepted transaction.
`include "cbor_head_encoder_top_assert.svh"

module cbor_head_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = cbe_pkg::CBE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  req_type,
  input  logic [63:0] value,
  output logic        strobe,
  output logic [7:0]  out_byte,
  output logic [3:0]  head_length,
  output logic        last
);
  import cbe_pkg::*;

  logic  push;
  logic  pop;
  logic  empty;
  logic  full;
  head_t wr_head;
  head_t rd_head;

  cbe_front u_front (
    .start    (start),
    .full     (full),
    .req_type (req_type),
    .value    (value),
    .busy     (busy),
    .push     (push),
    .head     (wr_head)
  );

  cbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_head (wr_head),
    .pop     (pop),
    .rd_head (rd_head),
    .empty   (empty),
    .full    (full)
  );

  cbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .rd_head     (rd_head),
    .pop         (pop),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .head_length (head_length),
    .last        (last)
  );

  // bytes of one head leave in consecutive cycles
  `CBE_ASSERT_NEXT(a_head_contiguous, clk, rst, strobe && !last, strobe, "head bytes not contiguous")
  // head length stays fixed across the bytes of one head
  `CBE_ASSERT_NEXT(a_len_stable, clk, rst, strobe && !last, head_length == $past(head_length), "head length changed mid head")
  // a multi byte head never reports a single byte length
  `CBE_ASSERT_SAME(a_len_multi, clk, rst, strobe && !last, head_length != 4'd1, "short head not marked last")
  // a classified request is held in the queue after it is taken
  `CBE_ASSERT_NEXT(a_push_lands, clk, rst, push, !empty, "taken request missing from queue")

endmodule

FILE: rtl/cbe_front.sv
// front end: accepts requests and classifies them into head descriptors
module cbe_front (
  input  logic             start,
  input  logic             full,
  input  logic [3:0]       req_type,
  input  logic [63:0]      value,
  output logic             busy,
  output logic             push,
  output cbe_pkg::head_t   head
);
  import cbe_pkg::*;

  logic        kind_ok;
  logic        is_nil;
  logic [2:0]  major;
  logic [63:0] arg;
  logic [4:0]  ai;
  logic [3:0]  len;

  assign busy = full;
  assign push = start && !full && kind_ok;

  always_comb begin
    kind_ok = 1'b1;
    is_nil  = 1'b0;
    major   = MT_UINT;
    arg     = value;
    case (req_kind_t'(req_type))
      REQ_UNSIGNED: begin
        major = MT_UINT;
      end
      REQ_SIGNED: begin
        if (value[63]) begin
          major = MT_NINT;
          arg   = ~value;
        end
      end
      REQ_NEG_MAG: begin
        major = MT_NINT;
        arg   = value - 64'd1;
      end
      REQ_BYTES: begin
        major = MT_BYTES;
      end
      REQ_TEXT: begin
        major = MT_TEXT;
      end
      REQ_ARRAY: begin
        major = MT_ARRAY;
      end
      REQ_MAP: begin
        major = MT_MAP;
      end
      REQ_TAG: begin
        major = MT_TAG;
      end
      REQ_SIMPLE: begin
        major = MT_SIMPLE;
        arg   = {56'd0, value[7:0]};
      end
      REQ_NIL: begin
        major  = MT_SIMPLE;
        is_nil = 1'b1;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  // shortest argument form
  always_comb begin
    if (arg < 64'd24) begin
      ai  = arg[4:0];
      len = 4'd1;
    end else if (arg[63:8] == 56'd0) begin
      ai  = AI_ONE;
      len = 4'd2;
    end else if (arg[63:16] == 48'd0) begin
      ai  = AI_TWO;
      len = 4'd3;
    end else if (arg[63:32] == 32'd0) begin
      ai  = AI_FOUR;
      len = 4'd5;
    end else begin
      ai  = AI_EIGHT;
      len = 4'd9;
    end
  end

  always_comb begin
    head.arg = arg;
    if (is_nil) begin
      head.first = NIL_BYTE;
      head.len   = 4'd1;
    end else begin
      head.first = {major, ai};
      head.len   = len;
    end
  end

endmodule

FILE: rtl/cbe_fifo.sv
// small queue of head descriptors between front and back
module cbe_fifo #(
  parameter int unsigned DEPTH = cbe_pkg::CBE_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cbe_pkg::head_t wr_head,
  input  logic           pop,
  output cbe_pkg::head_t rd_head,
  output logic           empty,
  output logic           full
);
  import cbe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  head_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign empty   = (count == CW'(0));
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_head = slots[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/cbe_back.sv
// back end: serializes one head descriptor into bytes, one per cycle
module cbe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  cbe_pkg::head_t rd_head,
  output logic           pop,
  output logic           strobe,
  output logic [7:0]     out_byte,
  output logic [3:0]     head_length,
  output logic           last
);
  import cbe_pkg::*;

  logic        active;
  logic [3:0]  cnt;
  head_t       cur;

  logic        emit_last;
  logic [3:0]  rem;
  logic [2:0]  sel;
  logic [7:0]  byte_next;

  assign emit_last = active && (cnt == cur.len - 4'd1);
  assign pop       = !empty && (!active || emit_last);

  // argument bytes go out most significant first
  assign rem       = cur.len - 4'd1 - cnt;
  assign sel       = rem[2:0];
  assign byte_next = (cnt == 4'd0) ? cur.first : cur.arg[{sel, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_head;
    end
    if (active) begin
      out_byte    <= byte_next;
      head_length <= cur.len;
      last        <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (emit_last) begin
        active <= 1'b0;
      end else if (active) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the cbor data item head encoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned STREAM_REQUESTS = 40;

  // request kinds past the nil code are taken but produce nothing
  localparam logic [3:0] REQ_UNUSED_LO = 4'd10;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

  // arguments below this value sit inline in the initial byte
  localparam logic [63:0] INLINE_LIMIT = 64'd24;

  typedef struct {
    logic [7:0] data;
    logic [3:0] len;
    logic       fin;
  } head_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  req_type = '0;
  logic [63:0] value = '0;
  logic        strobe;
  logic [7:0]  out_byte;
  logic [3:0]  head_length;
  logic        last;

  head_byte_t  pending_bytes[$];
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned unknown_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned long_heads = 0;
  int unsigned busy_stalls = 0;
  int unsigned cycle_count = 0;

  cbor_head_encoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .value       (value),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .head_length (head_length),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  function automatic void push_byte(input logic [7:0] data, input int hlen, input bit fin);
    head_byte_t hb;
    hb.data = data;
    hb.len  = hlen[3:0];
    hb.fin  = fin;
    pending_bytes.push_back(hb);
  endfunction

  // queues the bytes of the head that one request should produce
  function automatic void predict_head(input logic [3:0] kind, input logic [63:0] v);
    logic [2:0]  major;
    logic [63:0] arg;
    logic [4:0]  ai;
    int          extra;
    int          hlen;
    case (kind)
      REQ_UNSIGNED: begin major = MT_UINT;  arg = v; end
      REQ_SIGNED: begin
        if (v[63]) begin
          major = MT_NINT;
          arg   = ~v;
        end else begin
          major = MT_UINT;
          arg   = v;
        end
      end
      REQ_NEG_MAG:  begin major = MT_NINT;  arg = v - 64'd1; end
      REQ_BYTES:    begin major = MT_BYTES; arg = v; end
      REQ_TEXT:     begin major = MT_TEXT;  arg = v; end
      REQ_ARRAY:    begin major = MT_ARRAY; arg = v; end
      REQ_MAP:      begin major = MT_MAP;   arg = v; end
      REQ_TAG:      begin major = MT_TAG;   arg = v; end
      REQ_SIMPLE:   begin major = MT_SIMPLE; arg = {56'd0, v[7:0]}; end
      REQ_NIL: begin
        push_byte(NIL_BYTE, 1, 1'b1);
        return;
      end
      default: return;
    endcase
    if (arg < INLINE_LIMIT) begin
      extra = 0;
      ai    = arg[4:0];
    end else if (arg < 64'h100) begin
      extra = 1;
      ai    = AI_ONE;
    end else if (arg < 64'h1_0000) begin
      extra = 2;
      ai    = AI_TWO;
    end else if (arg < 64'h1_0000_0000) begin
      extra = 4;
      ai    = AI_FOUR;
    end else begin
      extra = 8;
      ai    = AI_EIGHT;
    end
    hlen = 1 + extra;
    push_byte({major, ai}, hlen, extra == 0);
    for (int k = 1; k <= extra; k++) begin
      push_byte(8'(arg >> (8 * (extra - k))), hlen, k == extra);
    end
  endfunction

  // one transaction on the request side, held until busy is low at an edge
  task automatic send_request(input logic [3:0] kind, input logic [63:0] arg);
    @(negedge clk);
    start    = 1'b1;
    req_type = kind;
    value    = arg;
    @(posedge clk);
    while (busy) begin
      busy_stalls++;
      @(posedge clk);
    end
    predict_head(kind, arg);
    requests_sent++;
    if (kind >= REQ_UNUSED_LO) unknown_sent++;
  endtask

  // drop start and put junk on the request fields
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start    = 1'b0;
      req_type = 4'($urandom);
      value    = {$urandom, $urandom};
    end
  endtask

  // argument spread over every head length and its boundaries
  function automatic logic [63:0] random_argument();
    int unsigned sh;
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 23));
      1: return 64'($urandom_range(24, 255));
      2: return 64'($urandom_range(256, 65535));
      3: return 64'($urandom_range(32'h1_0000, 32'hFFFF_FFFF));
      4: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 3))
          0: sh = 8;
          1: sh = 16;
          2: sh = 32;
          default: sh = 64;
        endcase
        if (sh == 64) return $urandom_range(0, 1) ? '1 : INLINE_LIMIT;
        return $urandom_range(0, 1) ? (64'd1 << sh) : (64'd1 << sh) - 64'd1;
      end
    endcase
  endfunction

  // turns an intended argument into the value field for the given kind
  function automatic logic [63:0] value_for(input logic [3:0] kind, input logic [63:0] arg);
    case (kind)
      REQ_SIGNED:  return $urandom_range(0, 1) ? ~arg : {1'b0, arg[62:0]};
      REQ_NEG_MAG: return arg + 64'd1;
      REQ_SIMPLE:  return {$urandom, $urandom_range(0, 1) ? $urandom : 32'd0} & ~64'hFF
                          | {56'd0, 8'($urandom_range(0, 255))};
      default:     return arg;
    endcase
  endfunction

  function automatic logic [3:0] random_kind();
    if ($urandom_range(0, 19) == 0) return 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    return 4'($urandom_range(REQ_UNSIGNED, REQ_NIL));
  endfunction

  task automatic test_directed_heads();
    send_request(REQ_UNSIGNED, 64'd0);
    send_request(REQ_UNSIGNED, 64'd23);
    send_request(REQ_UNSIGNED, 64'd24);
    send_request(REQ_UNSIGNED, 64'd255);
    send_request(REQ_UNSIGNED, 64'd256);
    send_request(REQ_UNSIGNED, 64'hFFFF);
    send_request(REQ_UNSIGNED, 64'hFFFF_FFFF);
    send_request(REQ_UNSIGNED, 64'h1_0000_0000);
    send_request(REQ_UNSIGNED, '1);
    send_request(REQ_SIGNED, '1);
    send_request(REQ_SIGNED, ~64'd24);
    send_request(REQ_SIGNED, 64'h8000_0000_0000_0000);
    send_request(REQ_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
    // zero magnitude wraps to the largest argument
    send_request(REQ_NEG_MAG, 64'd0);
    send_request(REQ_NEG_MAG, 64'd1);
    send_request(REQ_BYTES, 64'd24);
    send_request(REQ_TEXT, 64'h1_0000);
    send_request(REQ_ARRAY, 64'd0);
    send_request(REQ_MAP, 64'h1_0000_0000);
    send_request(REQ_TAG, '1);
    send_request(REQ_SIMPLE, 64'd23);
    send_request(REQ_SIMPLE, 64'hFFFF_FFFF_FFFF_FF18);
    send_request(REQ_SIMPLE, 64'd255);
    send_request(REQ_NIL, '1);
    send_request(REQ_UNUSED_LO, 64'd5);
    send_request(REQ_UNUSED_HI, '1);
    idle_cycles(12);
  endtask

  // back-to-back requests, nine-byte heads that keep the queue full, then one-byte heads
  task automatic test_back_to_back();
    logic [3:0] kind;
    for (int i = 0; i < STREAM_REQUESTS; i++) begin
      if (i < STREAM_REQUESTS / 2) begin
        kind = $urandom_range(0, 1) ? REQ_UNSIGNED : 4'($urandom_range(REQ_BYTES, REQ_TAG));
        send_request(kind, {1'b1, 31'($urandom), $urandom});
      end else begin
        send_request($urandom_range(0, 1) ? REQ_NIL : REQ_ARRAY, 64'($urandom_range(0, 23)));
      end
    end
    idle_cycles(12);
  endtask

  // bursts of random length, random gaps, now and then a long run without gaps
  task automatic test_random_heads();
    int unsigned burst;
    logic [3:0]  kind;
    int unsigned sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      repeat (burst) begin
        kind = random_kind();
        send_request(kind, value_for(kind, random_argument()));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 14));
    end
  endtask

  // compares each byte against the oldest expectation
  always @(posedge clk) begin
    head_byte_t want;
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 64'd0, {56'd0, out_byte});
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", 64'(want.data), 64'(out_byte));
        if (head_length !== want.len) begin
          report_mismatch("head_length", 64'(want.len), 64'(head_length));
        end
        if (last !== want.fin) report_mismatch("last", 64'(want.fin), 64'(last));
        if (last === 1'b1 && head_length == 4'd9) long_heads++;
        bytes_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected",
             cycle_count, pending_bytes.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_heads();
    test_back_to_back();
    test_random_heads();

    @(negedge clk);
    start = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d of unknown kind), %0d head bytes checked",
             requests_sent, unknown_sent, bytes_checked);
    $display("%0d nine-byte heads, %0d cycles held off by busy", long_heads, busy_stalls);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cbe_pkg.sv
rtl/cbe_front.sv
rtl/cbe_fifo.sv
rtl/cbe_back.sv
rtl/cbor_head_encoder_top.sv
sim/testbench.sv
